[rtl/core/btsp_pkg.sv]
package btsp_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int CNT_W     = 7;
    localparam int RISK_W    = 31;
    localparam int LEN_W     = 16;
    localparam int NRISK_W   = 32;
    localparam int NLEN_W    = 23;
    localparam int OLEN_W    = 22;

    localparam logic [NRISK_W-1:0] RISK_INF = 32'h7FFF_FFFF;
    localparam logic [NLEN_W-1:0]  LEN_INF  = 23'h7F_FFFF;
    localparam logic [OLEN_W-1:0]  LEN_OUT_MAX = 22'h3F_FFFF;
    localparam logic [CNT_W-1:0]   NODE_COUNT_RESET = 7'd64;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0]  addr;
        logic               we;
        logic [NRISK_W-1:0] wdata;
    } node_wr_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [RISK_W-1:0] wrisk;
        logic [LEN_W-1:0]  wlen;
        logic [ADDR_W-1:0] raddr;
    } adj_cmd_t;

endpackage

[rtl/core/btsp_if.sv]
interface btsp_in_if (input logic clk);
    logic        valid;
    logic        ready;
    logic        kind;
    logic [5:0]  src_node;
    logic [5:0]  dst_node;
    logic [30:0] edge_risk;
    logic [15:0] edge_length;
    modport source (output valid, kind, src_node, dst_node, edge_risk, edge_length,
                    input ready);
    modport sink (input valid, kind, src_node, dst_node, edge_risk, edge_length,
                  output ready);
endinterface

interface btsp_out_if (input logic clk);
    logic        valid;
    logic        ready;
    logic        found;
    logic [30:0] best_risk;
    logic [21:0] best_length;
    modport source (output valid, found, best_risk, best_length, input ready);
    modport sink (input valid, found, best_risk, best_length, output ready);
endinterface

interface btsp_cfg_if (input logic clk);
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/core/btsp_adj_mem.sv]
module btsp_adj_mem (
    input  logic                        clk,
    input  btsp_pkg::adj_cmd_t          cmd,
    output logic [btsp_pkg::RISK_W-1:0] rd_risk,
    output logic [btsp_pkg::LEN_W-1:0]  rd_len
);
    logic [btsp_pkg::RISK_W-1:0] risk_mem [btsp_pkg::MAX_NODES*btsp_pkg::MAX_NODES];
    logic [btsp_pkg::LEN_W-1:0]  len_mem  [btsp_pkg::MAX_NODES*btsp_pkg::MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            risk_mem[cmd.waddr] <= cmd.wrisk;
            len_mem[cmd.waddr]  <= cmd.wlen;
        end
        rd_risk <= risk_mem[cmd.raddr];
        rd_len  <= len_mem[cmd.raddr];
    end
endmodule

[rtl/core/btsp_node_mem.sv]
module btsp_node_mem (
    input  logic                         clk,
    input  btsp_pkg::node_wr_t           wr,
    input  logic [btsp_pkg::NODE_W-1:0]  raddr,
    output logic [btsp_pkg::NRISK_W-1:0] rdata
);
    // One key per node; register both ports so key scan runs at one node per cycle.
    logic [btsp_pkg::NRISK_W-1:0] key_mem [btsp_pkg::MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (wr.we)
            key_mem[wr.addr] <= wr.wdata;
        rdata <= key_mem[raddr];
    end
endmodule

[rtl/core/bottleneck_then_shortest_path.sv]
// Edge load: transfers are taken back to back while the block is idle and no result is pending.
// Run: a risk pass, then a length pass if the target is reachable, walking one node key
//   or one adjacency entry per cycle; each pass first resets the node keys, and a final
//   sweep clears the present rows.
// The result waits in an output register; the input is not ready during a run.
// Reset (rst_n, async low): node_count = 64, then a sweep clears the present rows.
module bottleneck_then_shortest_path (
    input logic         clk,
    input logic         rst_n,
    btsp_in_if.sink     in_ch,
    btsp_out_if.source  out_ch,
    btsp_cfg_if.sink    cfg
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SCANW = 4'd3;
    localparam logic [3:0] S_RELAX = 4'd4;
    localparam logic [3:0] S_RELW  = 4'd5;
    localparam logic [3:0] S_NEXT  = 4'd6;
    localparam logic [3:0] S_TGT   = 4'd7;
    localparam logic [3:0] S_TGTW  = 4'd8;
    localparam logic [3:0] S_CLEAR = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_WIPE  = 4'd11;

    localparam int NW = btsp_pkg::NODE_W;
    localparam int KW = btsp_pkg::NRISK_W;

    logic [3:0]          state_reg, state_next;
    logic [6:0]          ncount_reg;
    logic                pass_reg;          // 0 = risk, 1 = length
    logic [NW:0]         idx_reg;           // scan / relax index
    logic [NW:0]         iter_reg;
    logic [NW-1:0]       cur_reg;           // node being settled
    logic [KW-1:0]       cur_key_reg;
    logic [NW:0]         best_reg;          // best index, MAX_NODES = none
    logic [KW-1:0]       best_key_reg;
    logic [btsp_pkg::RISK_W-1:0] limit_reg;
    logic [btsp_pkg::MAX_NODES-1:0] done_reg;
    logic [btsp_pkg::MAX_NODES-1:0] present_mem [btsp_pkg::MAX_NODES];
    logic [btsp_pkg::MAX_NODES-1:0] pres_row_reg;   // present row of the settled node
    logic                found_reg;
    logic [btsp_pkg::OLEN_W-1:0] len_out_reg;
    logic                ovalid_reg;

    logic [NW:0]         n_act;
    logic [NW-1:0]       tgt;
    logic [NW-1:0]       idx_d_reg;         // index whose read data is arriving
    logic                pres_d_reg;
    logic [NW-1:0]       pres_raddr;
    logic                wipe_row;
    btsp_pkg::adj_cmd_t  adj_cmd;
    btsp_pkg::node_wr_t  nwr;
    logic [NW-1:0]       nraddr;
    logic [KW-1:0]       nrdata;
    logic [btsp_pkg::RISK_W-1:0] rd_risk;
    logic [btsp_pkg::LEN_W-1:0]  rd_len;
    logic [KW-1:0]       cand;
    logic                take;

    // Clamp node_count into 2..MAX_NODES.
    always_comb
    begin
        if (ncount_reg < 7'd2)
            n_act = 7'd2;
        else if (ncount_reg > 7'd64)
            n_act = 7'd64;
        else
            n_act = ncount_reg;
    end
    assign tgt = NW'(n_act - 7'd1);

    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg.ready   = 1'b1;
    assign out_ch.valid       = ovalid_reg;
    assign out_ch.found       = found_reg;
    assign out_ch.best_risk   = found_reg ? limit_reg : '0;
    assign out_ch.best_length = len_out_reg;

    logic in_xfer;
    assign in_xfer = in_ch.valid && in_ch.ready;

    always_comb
    begin
        adj_cmd.we    = in_xfer && (in_ch.kind == btsp_pkg::KIND_LOAD);
        adj_cmd.waddr = {in_ch.src_node, in_ch.dst_node};
        adj_cmd.wrisk = in_ch.edge_risk;
        adj_cmd.wlen  = in_ch.edge_length;
        adj_cmd.raddr = {cur_reg, idx_reg[NW-1:0]};
    end

    btsp_adj_mem u_adj (
        .clk     (clk),
        .cmd     (adj_cmd),
        .rd_risk (rd_risk),
        .rd_len  (rd_len)
    );

    // Present bits: one row per source node. Fetch the row of the node about to be
    // settled while in S_SCANW, so it is registered before the relax walk starts.
    assign pres_raddr = (state_reg == S_SCANW) ? best_reg[NW-1:0] : cur_reg;
    assign wipe_row   = (state_reg == S_CLEAR) || (state_reg == S_WIPE);

    always_ff @(posedge clk)
    begin
        if (adj_cmd.we)
            present_mem[in_ch.src_node][in_ch.dst_node] <= 1'b1;
        else if (wipe_row)
            present_mem[idx_reg[NW-1:0]] <= '0;
        pres_row_reg <= present_mem[pres_raddr];
    end

    // Node key read address: scan index, or relax target j.
    assign nraddr = idx_reg[NW-1:0];

    // Shared unit: path value through cur for the entry arriving now.
    always_comb
    begin
        if (!pass_reg)
            cand = ({1'b0, rd_risk} > cur_key_reg) ? {1'b0, rd_risk} : cur_key_reg;
        else
            cand = cur_key_reg + KW'(rd_len);
        take = pres_d_reg && !done_reg[idx_d_reg] && (cand < nrdata)
               && (!pass_reg || (rd_risk <= limit_reg));
    end

    always_comb
    begin
        nwr.we    = 1'b0;
        nwr.addr  = idx_d_reg;
        nwr.wdata = cand;
        if (state_reg == S_INIT)
        begin
            nwr.we    = 1'b1;
            nwr.addr  = idx_reg[NW-1:0];
            nwr.wdata = (idx_reg == '0) ? '0 : (pass_reg ? KW'(btsp_pkg::LEN_INF)
                                                         : btsp_pkg::RISK_INF);
        end
        else if ((state_reg == S_RELAX || state_reg == S_RELW) && idx_d_reg != '0)
            nwr.we = take;
    end

    btsp_node_mem u_node (
        .clk   (clk),
        .wr    (nwr),
        .raddr (nraddr),
        .rdata (nrdata)
    );

    logic [KW-1:0] inf_key;
    assign inf_key = pass_reg ? KW'(btsp_pkg::LEN_INF) : btsp_pkg::RISK_INF;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_xfer && in_ch.kind == btsp_pkg::KIND_RUN) state_next = S_INIT;
            S_INIT:  if (idx_reg == 7'd63) state_next = S_SCAN;
            S_SCAN:  if (idx_reg == n_act) state_next = S_SCANW;
            S_SCANW: state_next = (best_reg == 7'd64 || iter_reg == n_act) ? S_TGT : S_RELAX;
            S_RELAX: if (idx_reg == n_act) state_next = S_RELW;
            S_RELW:  state_next = S_NEXT;
            S_NEXT:  state_next = S_SCAN;
            S_TGT:   state_next = S_TGTW;
            S_TGTW:  state_next = (!pass_reg && nrdata < btsp_pkg::RISK_INF) ? S_INIT : S_CLEAR;
            S_CLEAR: if (idx_reg == 7'd63) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            S_WIPE:  if (idx_reg == 7'd63) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_WIPE;
            ncount_reg <= btsp_pkg::NODE_COUNT_RESET;
            ovalid_reg <= 1'b0;
            pass_reg   <= 1'b0;
            idx_reg    <= '0;
            iter_reg   <= '0;
            done_reg   <= '0;
            pres_d_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pres_d_reg <= 1'b0;
            if (cfg.valid && cfg.ready)
                ncount_reg <= cfg.data;
            if (out_ch.valid && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg  <= '0;
                    pass_reg <= 1'b0;
                end
                S_INIT:
                begin
                    // Reset node keys, pick node 0 first with key 0.
                    idx_reg      <= (idx_reg == 7'd63) ? 7'd0 : idx_reg + 7'd1;
                    done_reg     <= '0;
                    iter_reg     <= '0;
                    best_reg     <= 7'd64;
                    best_key_reg <= inf_key;
                end
                S_SCAN:
                begin
                    // Data for index idx-1 arrives now; lowest index wins ties.
                    if (idx_reg != '0)
                    begin
                        if (!done_reg[idx_d_reg] && nrdata < inf_key
                            && (best_reg == 7'd64 || nrdata < best_key_reg))
                        begin
                            best_reg     <= {1'b0, idx_d_reg};
                            best_key_reg <= nrdata;
                        end
                    end
                    idx_d_reg <= idx_reg[NW-1:0];
                    if (idx_reg != n_act)
                        idx_reg <= idx_reg + 7'd1;
                end
                S_SCANW:
                begin
                    if (best_reg == 7'd64 || iter_reg == n_act)
                        idx_reg <= {1'b0, tgt};
                    else
                    begin
                        cur_reg     <= best_reg[NW-1:0];
                        cur_key_reg <= best_key_reg;
                        done_reg[best_reg[NW-1:0]] <= 1'b1;
                        idx_reg     <= 7'd1;
                    end
                end
                S_RELAX, S_RELW:
                begin
                    if (state_reg == S_RELAX)
                    begin
                        idx_d_reg  <= idx_reg[NW-1:0];
                        pres_d_reg <= (idx_reg != n_act) && (idx_reg != '0)
                                      && pres_row_reg[idx_reg[NW-1:0]];
                        if (idx_reg != n_act)
                            idx_reg <= idx_reg + 7'd1;
                    end
                end
                S_NEXT:
                begin
                    iter_reg     <= iter_reg + 7'd1;
                    idx_reg      <= '0;
                    best_reg     <= 7'd64;
                    best_key_reg <= inf_key;
                end
                S_TGT: ;
                S_TGTW:
                begin
                    idx_reg <= '0;
                    if (!pass_reg)
                    begin
                        if (nrdata >= btsp_pkg::RISK_INF)
                        begin
                            found_reg   <= 1'b0;
                            len_out_reg <= '0;
                        end
                        else
                        begin
                            limit_reg <= nrdata[btsp_pkg::RISK_W-1:0];
                            found_reg <= 1'b1;
                            pass_reg  <= 1'b1;
                        end
                    end
                    else
                    begin
                        len_out_reg <= (nrdata > KW'(btsp_pkg::LEN_OUT_MAX))
                                       ? btsp_pkg::LEN_OUT_MAX
                                       : nrdata[btsp_pkg::OLEN_W-1:0];
                    end
                end
                S_CLEAR, S_WIPE:
                    idx_reg <= idx_reg + 7'd1;
                S_OUT:   ovalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Relax never writes the source node's key.
    a_no_src_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RELAX || state_reg == S_RELW) && nwr.we) |-> (nwr.addr != '0))
        else $error("relax wrote node 0");
    // Result register only fills after the clear sweep.
    a_out_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result without clear");
    // No input is taken while a result is pending.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !in_ch.ready)
        else $error("ready while result pending");
endmodule
